[rtl/mtg_pkg.sv]
// mtg_pkg: shared constants, control types and word functions of the mt19937 generator
// depends on nothing; imported by mtg_feed, mt19937_generator and tb
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS_DEF = 624;
    localparam int MT_SHIFT_M      = 397;

    localparam logic [31:0] MT_INIT_MULT = 32'h6c078965;
    localparam logic [31:0] MT_UPPER     = 32'h80000000;
    localparam logic [31:0] MT_LOWER     = 32'h7fffffff;
    localparam logic [31:0] MT_MATRIX    = 32'h9908b0df;
    localparam logic [31:0] MT_TMASK_B   = 32'h9d2c5680;
    localparam logic [31:0] MT_TMASK_C   = 32'hefc60000;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    localparam int TEMPER_U = 11;
    localparam int TEMPER_S = 7;
    localparam int TEMPER_T = 15;
    localparam int TEMPER_L = 18;

    localparam int UNDO_U_STEPS = 32 / TEMPER_U + 1;
    localparam int UNDO_S_STEPS = 32 / TEMPER_S + 1;
    localparam int UNDO_T_STEPS = 32 / TEMPER_T + 1;
    localparam int UNDO_L_STEPS = 32 / TEMPER_L + 1;

    localparam logic [1:0] KIND_RESEED = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_LOAD   = 2'd2;

    typedef enum logic [1:0] {
        FEED_ROTATE,
        FEED_TWIST,
        FEED_INIT,
        FEED_LOAD
    } feed_mode_t;

    typedef struct packed {
        feed_mode_t mode;
        logic       first;
    } feed_ctrl_t;

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] w;
        y = (cur & MT_UPPER) | (nxt & MT_LOWER);
        w = far ^ (y >> 1);
        if (y[0])
        begin
            w = w ^ MT_MATRIX;
        end
        return w;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x >> TEMPER_U);
        t = t ^ ((t << TEMPER_S) & MT_TMASK_B);
        t = t ^ ((t << TEMPER_T) & MT_TMASK_C);
        t = t ^ (t >> TEMPER_L);
        return t;
    endfunction

    // undoes the last two tempering steps
    function automatic logic [31:0] untemper_front(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x;
        for (int k = 0; k < UNDO_L_STEPS; k++)
        begin
            a = x ^ (a >> TEMPER_L);
        end
        b = a;
        for (int k = 0; k < UNDO_T_STEPS; k++)
        begin
            b = a ^ ((b << TEMPER_T) & MT_TMASK_C);
        end
        return b;
    endfunction

    // undoes the first two tempering steps
    function automatic logic [31:0] untemper_back(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x;
        for (int k = 0; k < UNDO_S_STEPS; k++)
        begin
            a = x ^ ((a << TEMPER_S) & MT_TMASK_B);
        end
        b = a;
        for (int k = 0; k < UNDO_U_STEPS; k++)
        begin
            b = a ^ (b >> TEMPER_U);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/mtg_cell.sv]
// mtg_cell: one 32-bit state word of the shift ring
// depends on nothing; instantiated once per state word by mt19937_generator
`default_nettype none

module mtg_cell (
    input  wire logic        clk,
    input  wire logic        shift,
    input  wire logic [31:0] word_in,
    output logic      [31:0] word
);

    logic [31:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= word_in;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

[rtl/mtg_feed.sv]
// mtg_feed: word fed into the tail of the ring (rotate, twist, seed recurrence, load)
// depends on mtg_pkg; instantiated by mt19937_generator
`default_nettype none

module mtg_feed #(
    parameter int IDX_W = 10
) (
    input  wire mtg_pkg::feed_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]    init_index,
    input  wire logic [31:0]         head_word,
    input  wire logic [31:0]         second_word,
    input  wire logic [31:0]         far_word,
    input  wire logic [31:0]         last_word,
    input  wire logic [31:0]         seed_word,
    input  wire logic [31:0]         load_word,
    output logic      [31:0]         tail_word,
    output logic      [31:0]         tempered
);

    import mtg_pkg::*;

    logic [31:0] twisted;
    logic [31:0] mixed;
    logic [31:0] product;
    logic [31:0] init_word;

    assign twisted   = twist_word(head_word, second_word, far_word);
    assign mixed     = last_word ^ (last_word >> 30);
    assign product   = MT_INIT_MULT * mixed;
    assign init_word = ctrl.first ? seed_word : product + 32'(init_index);
    assign tempered  = temper(twisted);

    always_comb
    begin
        case (ctrl.mode)
            FEED_TWIST: tail_word = twisted;
            FEED_INIT:  tail_word = init_word;
            FEED_LOAD:  tail_word = load_word;
            default:    tail_word = head_word;
        endcase
    end

endmodule

`default_nettype wire

[rtl/mt19937_generator.sv]
// mt19937_generator: MT19937 generator built as a ring of 624 word cells
// depends on mtg_pkg, mtg_cell, mtg_feed
//
// channel   direction  signals                    transfer
// command   in         start, busy, kind, observed start high while busy low
// result    out        value_valid, value         value_valid high, one cycle
// config    in         seed_we, seed              seed_we high
//
// a draw completes without seeking when the ring already sits at the draw index; the twist
// runs one word per draw through the ring head, taps 0, 1 and 397
// a reseed feeds the seed word after the transfer cycle, then one multiply of the seed
// recurrence per further word
// a load untempers the observed word in two registered steps, finishes any partial twist,
// then rotates to the load position; the first draw after loads rotates back to word 0
// reset clears the control state only; the state words are valid after a reseed
// or 624 loads; results cannot be stalled and appear the cycle after the twist step
`default_nettype none

module mt19937_generator #(
    parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] observed,
    output logic             value_valid,
    output logic      [31:0] value,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed
);

    import mtg_pkg::*;

    localparam int IDX_W = $clog2(STATE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESEED,
        ST_LOAD_PREP,
        ST_LOAD_RUN,
        ST_DRAW_SEEK
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] rot_reg;
    logic [IDX_W-1:0] draw_index_reg;
    logic [IDX_W-1:0] load_pos_reg;
    logic [IDX_W-1:0] count_reg;
    logic [31:0]      seed_reg;
    logic [31:0]      half_reg;
    logic [31:0]      load_word_reg;
    logic [31:0]      value_reg;
    logic             value_valid_reg;

    logic [IDX_W-1:0] rot_next;
    logic [IDX_W-1:0] draw_index_next;
    logic [IDX_W-1:0] load_pos_next;
    logic [IDX_W-1:0] count_next;

    logic             shift;
    logic             twist_out;
    feed_ctrl_t       ctrl;
    logic [31:0]      tail_word;
    logic [31:0]      tempered;
    logic [31:0]      word [STATE_WORDS];

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (v == LAST_IDX) ? '0 : v + 1'b1;
    endfunction

    assign rot_next        = wrap_inc(rot_reg);
    assign draw_index_next = wrap_inc(draw_index_reg);
    assign load_pos_next   = wrap_inc(load_pos_reg);
    assign count_next      = wrap_inc(count_reg);

    // ring: each cell takes its upper neighbor, the last one takes the feed
    for (genvar k = 0; k < STATE_WORDS; k++)
    begin : g_cell
        if (k < STATE_WORDS - 1)
        begin : g_mid
            mtg_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .word_in (word[k+1]),
                .word    (word[k])
            );
        end
        else
        begin : g_last
            mtg_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .word_in (tail_word),
                .word    (word[k])
            );
        end
    end

    mtg_feed #(
        .IDX_W (IDX_W)
    ) u_feed (
        .ctrl        (ctrl),
        .init_index  (count_reg),
        .head_word   (word[0]),
        .second_word (word[1]),
        .far_word    (word[MT_SHIFT_M]),
        .last_word   (word[STATE_WORDS-1]),
        .seed_word   (seed_reg),
        .load_word   (load_word_reg),
        .tail_word   (tail_word),
        .tempered    (tempered)
    );

    always_comb
    begin
        shift      = 1'b0;
        ctrl.mode  = FEED_ROTATE;
        ctrl.first = (count_reg == '0);
        twist_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind == KIND_DRAW && rot_reg == draw_index_reg)
                begin
                    shift     = 1'b1;
                    ctrl.mode = FEED_TWIST;
                    twist_out = 1'b1;
                end
            end
            ST_RESEED:
            begin
                shift     = 1'b1;
                ctrl.mode = FEED_INIT;
            end
            ST_LOAD_RUN:
            begin
                shift = 1'b1;
                if (draw_index_reg != '0)
                begin
                    ctrl.mode = FEED_TWIST;
                end
                else if (rot_reg == load_pos_reg)
                begin
                    ctrl.mode = FEED_LOAD;
                end
            end
            ST_DRAW_SEEK:
            begin
                shift = 1'b1;
                if (rot_reg == draw_index_reg)
                begin
                    ctrl.mode = FEED_TWIST;
                    twist_out = 1'b1;
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (seed_we)
        begin
            seed_reg <= seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rot_reg         <= '0;
            draw_index_reg  <= '0;
            load_pos_reg    <= '0;
            count_reg       <= '0;
            half_reg        <= '0;
            load_word_reg   <= '0;
            value_reg       <= '0;
            value_valid_reg <= 1'b0;
        end
        else
        begin
            value_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        case (kind)
                            KIND_RESEED:
                            begin
                                count_reg <= '0;
                                state_reg <= ST_RESEED;
                            end
                            KIND_DRAW:
                            begin
                                if (rot_reg == draw_index_reg)
                                begin
                                    rot_reg         <= rot_next;
                                    draw_index_reg  <= draw_index_next;
                                    value_reg       <= tempered;
                                    value_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_DRAW_SEEK;
                                end
                            end
                            KIND_LOAD:
                            begin
                                half_reg  <= untemper_front(observed);
                                state_reg <= ST_LOAD_PREP;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RESEED:
                begin
                    count_reg <= count_next;
                    if (count_reg == LAST_IDX)
                    begin
                        rot_reg        <= '0;
                        draw_index_reg <= '0;
                        load_pos_reg   <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_LOAD_PREP:
                begin
                    load_word_reg <= untemper_back(half_reg);
                    state_reg     <= ST_LOAD_RUN;
                end
                ST_LOAD_RUN:
                begin
                    rot_reg <= rot_next;
                    if (draw_index_reg != '0)
                    begin
                        draw_index_reg <= draw_index_next;
                    end
                    else if (rot_reg == load_pos_reg)
                    begin
                        load_pos_reg <= load_pos_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_DRAW_SEEK:
                begin
                    rot_reg <= rot_next;
                    if (rot_reg == draw_index_reg)
                    begin
                        draw_index_reg  <= draw_index_next;
                        value_reg       <= tempered;
                        value_valid_reg <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign value       = value_reg;
    assign value_valid = value_valid_reg;

    // a result only follows a twist at the ring head
    assert property (@(posedge clk) disable iff (!rst_n)
        value_valid |-> $past(twist_out))
        else $error("result without a twist step");

    // a partial twist keeps the ring aligned with the draw index
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && draw_index_reg != '0) |-> (rot_reg == draw_index_reg))
        else $error("ring out of step with draw index");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rot_reg <= LAST_IDX) && (draw_index_reg <= LAST_IDX) && (load_pos_reg <= LAST_IDX))
        else $error("index beyond state size");

    // a load ends with the draw index cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD_RUN && ctrl.mode == FEED_LOAD) |=> (draw_index_reg == '0))
        else $error("draw index not cleared by load");

    // reseed and load transfers hold the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_RESEED || kind == KIND_LOAD)) |=> busy)
        else $error("reseed or load did not start");

endmodule

`default_nettype wire

[dv/tb.sv]
// tb: self-checking testbench for mt19937_generator, reseed, draw and load commands
// holds its own generator model in a scoreboard class and checks every drawn word
// depends on mtg_pkg and the mt19937_generator rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::KIND_RESEED;
    import mtg_pkg::KIND_DRAW;
    import mtg_pkg::KIND_LOAD;

    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam int          WORD_COUNT    = 624;
    localparam int          TAP_OFFSET    = 397;
    localparam logic [31:0] INIT_FACTOR   = 32'h6c078965;
    localparam logic [31:0] HI_MASK       = 32'h80000000;
    localparam logic [31:0] LO_MASK       = 32'h7fffffff;
    localparam logic [31:0] TWIST_XOR     = 32'h9908b0df;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;
    localparam logic [31:0] RESET_SEED    = 32'd5489;
    localparam int          ITEM_TARGET   = 1150;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          IDLE_LIMIT    = 8000;

    class mt_scoreboard;
        logic [31:0] words [WORD_COUNT];
        int unsigned draw_pos;
        int unsigned load_pos;
        logic [31:0] seed_word;
        logic [31:0] expected_words [$];
        int errors;
        int draws;
        int reseeds;
        int loads;
        int ignored;
        int draw_run;
        int longest_run;

        function new();
            foreach (words[i])
            begin
                words[i] = '0;
            end
            draw_pos    = 0;
            load_pos    = 0;
            seed_word   = RESET_SEED;
            errors      = 0;
            draws       = 0;
            reseeds     = 0;
            loads       = 0;
            ignored     = 0;
            draw_run    = 0;
            longest_run = 0;
        endfunction

        function void set_seed(input logic [31:0] s);
            seed_word = s;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function logic [31:0] temper_word(input logic [31:0] x);
            logic [31:0] t;
            t = x ^ (x >> 11);
            t = t ^ ((t << 7) & TEMPER_MASK_B);
            t = t ^ ((t << 15) & TEMPER_MASK_C);
            t = t ^ (t >> 18);
            return t;
        endfunction

        function logic [31:0] unshift_right(input logic [31:0] x, input int s);
            logic [31:0] y;
            y = x;
            for (int k = 0; k < 32 / s + 1; k++)
            begin
                y = x ^ (y >> s);
            end
            return y;
        endfunction

        function logic [31:0] unshift_left(input logic [31:0] x, input int s,
                                           input logic [31:0] m);
            logic [31:0] y;
            y = x;
            for (int k = 0; k < 32 / s + 1; k++)
            begin
                y = x ^ ((y << s) & m);
            end
            return y;
        endfunction

        function logic [31:0] untemper_word(input logic [31:0] x);
            logic [31:0] t;
            t = unshift_right(x, 18);
            t = unshift_left(t, 15, TEMPER_MASK_C);
            t = unshift_left(t, 7, TEMPER_MASK_B);
            t = unshift_right(t, 11);
            return t;
        endfunction

        function void twist_state();
            logic [31:0] y;
            logic [31:0] w;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                y = (words[i] & HI_MASK) | (words[(i + 1) % WORD_COUNT] & LO_MASK);
                w = words[(i + TAP_OFFSET) % WORD_COUNT] ^ (y >> 1);
                if (y[0])
                begin
                    w = w ^ TWIST_XOR;
                end
                words[i] = w;
            end
        endfunction

        // advance the model by one accepted command transfer
        function void note_command(input logic [1:0] k, input logic [31:0] obs);
            case (k)
                KIND_RESEED:
                begin
                    words[0] = seed_word;
                    for (int i = 1; i < WORD_COUNT; i++)
                    begin
                        words[i] = INIT_FACTOR * (words[i - 1] ^ (words[i - 1] >> 30))
                                   + 32'(i);
                    end
                    draw_pos = 0;
                    load_pos = 0;
                    draw_run = 0;
                    reseeds++;
                end
                KIND_DRAW:
                begin
                    if (draw_pos == 0)
                    begin
                        twist_state();
                    end
                    expected_words.push_back(temper_word(words[draw_pos]));
                    draw_pos = (draw_pos + 1) % WORD_COUNT;
                    draw_run++;
                    if (draw_run > longest_run)
                    begin
                        longest_run = draw_run;
                    end
                    draws++;
                end
                KIND_LOAD:
                begin
                    words[load_pos] = untemper_word(obs);
                    load_pos = (load_pos + 1) % WORD_COUNT;
                    draw_pos = 0;
                    draw_run = 0;
                    loads++;
                end
                default:
                begin
                    ignored++;
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            if (errors < 50)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_value(input logic [31:0] v);
            logic [31:0] want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("value %h with no draw pending", v));
            end
            else
            begin
                want = expected_words.pop_front();
                if (v !== want)
                begin
                    report_mismatch($sformatf("value got %h want %h", v, want));
                end
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] observed;
    logic        value_valid;
    logic [31:0] value;
    logic        seed_we;
    logic [31:0] seed;

    mt_scoreboard sb = new();

    int items_sent  = 0;
    int seed_writes = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    mt19937_generator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .observed    (observed),
        .value_valid (value_valid),
        .value       (value),
        .seed_we     (seed_we),
        .seed        (seed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_command(kind, observed);
            end
            if (value_valid)
            begin
                sb.check_value(value);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || value_valid)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(50, 200);
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
            end
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_command(input logic [1:0] k, input logic [31:0] obs);
        start    <= 1'b1;
        kind     <= k;
        observed <= obs;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (k != KIND_UNUSED)
        begin
            items_sent++;
        end
        pace_sender();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        seed_we <= 1'b1;
        seed    <= s;
        @(posedge clk);
        seed_we <= 1'b0;
        sb.set_seed(s);
        seed_writes++;
    endtask

    // mix of draws with some loads, noise and the odd reseed
    task automatic run_mix(input int n, input int load_pct, input int noise_pct);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < noise_pct)
            begin
                send_command(KIND_UNUSED, $urandom());
            end
            else if (r < noise_pct + load_pct)
            begin
                send_command(KIND_LOAD, $urandom());
            end
            else if (r == 99)
            begin
                send_command(KIND_RESEED, $urandom());
            end
            else
            begin
                send_command(KIND_DRAW, $urandom());
            end
        end
    endtask

    initial
    begin
        int  n;
        bit  long_done;
        logic [31:0] s;

        long_done = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_RESEED;
        observed  = '0;
        seed_we   = 1'b0;
        seed      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_command(KIND_UNUSED, 32'h0);
        send_command(KIND_RESEED, 32'hffffffff);
        send_command(KIND_DRAW, 32'h0);
        send_command(KIND_DRAW, 32'hffffffff);
        send_command(KIND_DRAW, $urandom());
        send_command(KIND_UNUSED, 32'hffffffff);
        send_command(KIND_DRAW, $urandom());
        drain_results();
        write_seed(32'h0);
        send_command(KIND_RESEED, 32'h0);
        send_command(KIND_DRAW, 32'h0);
        send_command(KIND_DRAW, $urandom());
        drain_results();
        write_seed(32'hffffffff);
        send_command(KIND_RESEED, $urandom());
        send_command(KIND_DRAW, $urandom());
        send_command(KIND_DRAW, $urandom());
        send_command(KIND_LOAD, 32'h0);
        send_command(KIND_LOAD, 32'hffffffff);
        send_command(KIND_DRAW, 32'hffffffff);
        send_command(KIND_DRAW, $urandom());
        send_command(KIND_LOAD, 32'h80000001);
        send_command(KIND_DRAW, $urandom());
        send_command(KIND_RESEED, $urandom());
        send_command(KIND_DRAW, $urandom());

        // random sessions, each opened by a reseed
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain_results();
                case ($urandom_range(0, 5))
                    0: s = 32'h0;
                    1: s = 32'hffffffff;
                    default: s = $urandom();
                endcase
                write_seed(s);
            end
            send_command(KIND_RESEED, $urandom());
            if (!long_done && items_sent > 300)
            begin
                // long enough to wrap the draw index and twist twice
                long_done = 1'b1;
                repeat (660) send_command(KIND_DRAW, $urandom());
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(2, 30);
                repeat (n) send_command(KIND_LOAD, $urandom());
                run_mix($urandom_range(10, 40), 3, 3);
            end
            else
            begin
                run_mix($urandom_range(10, 80), 4, 3);
            end
        end

        drain_results();
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d values never arrived", sb.pending()));
        end
        $display("run: %0d draws, %0d reseeds, %0d loads, %0d ignored commands, %0d seed writes",
                 sb.draws, sb.reseeds, sb.loads, sb.ignored, seed_writes);
        $display("longest unbroken draw run %0d, mismatches %0d", sb.longest_run, sb.errors);
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
